/* src/consistent_hash_ring_router_unit_macros.svh */
// Assertion macros for the consistent hash ring router unit.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef CONSISTENT_HASH_RING_ROUTER_UNIT_MACROS_SVH
`define CONSISTENT_HASH_RING_ROUTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CHR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CHR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define CHR_ASSERT(label, clk, rst_n, prop, msg)
`define CHR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* src/chr_pkg.sv */
// Package for the consistent hash ring router: sizes, codes and beat types.
// No dependencies.
package chr_pkg;
    localparam int MaxNodes  = 16;
    localparam int Vnodes    = 3;
    localparam int Placed    = (Vnodes < 3) ? Vnodes : 3;
    localparam int RingDepth = MaxNodes * Vnodes;
    localparam int NodeAw    = $clog2(MaxNodes);
    localparam int RingAw    = $clog2(RingDepth);
    localparam int NodeCw    = $clog2(MaxNodes + 1);
    localparam int RingCw    = $clog2(RingDepth + 1);

    localparam logic [1:0] OpLookup = 2'd0;
    localparam logic [1:0] OpAdd    = 2'd1;
    localparam logic [1:0] OpRemove = 2'd2;

    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StIdLow    = 3'd1;
    localparam logic [2:0] StNotFound = 3'd2;
    localparam logic [2:0] StDup      = 3'd3;
    localparam logic [2:0] StFull     = 3'd4;
    localparam logic [2:0] StEmpty    = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key_hash;
        logic [31:0] node_id;
        logic [63:0] vnode_hash_a;
        logic [63:0] vnode_hash_b;
        logic [63:0] vnode_hash_c;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] owner_node;
        logic [31:0] ring_version;
        logic [4:0]  nodes_held;
    } t_out_beat;
endpackage

/* src/chr_ram.sv */
// Generic synchronous RAM with one write port and one read port, registered read.
// No dependencies.
module chr_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* src/consistent_hash_ring_router_unit.sv */
// Consistent hash ring router unit: top level and sequencer.
// Depends on chr_pkg, chr_ram and consistent_hash_ring_router_unit_macros.svh.
//
// Usage: one input beat (operation, key hash, node id, three vnode hashes)
// gives one output beat (status, owner, ring version, nodes held). Both
// channels use valid/stall; a beat moves when valid is high and stall low.
// The block works on one beat at a time; o_in_stall stays high while a beat
// is in flight or the output register is full.
// Lookup runs one binary search over the ring (at most 6 probes for 48
// entries); add runs six searches (three duplicate checks, three insert
// positions), each insert shifting the ring tail up by one entry; remove
// scans and shifts the node list and compacts the whole ring.
// The ring key and owner memories have one read and one write port each and
// a registered read.
// Reset clears the counters and the sequencer; memory contents stay
// undefined and their data is never used past the fill counts. When the receiver
// stalls, the result holds in the output register and no new beat is taken.
`include "consistent_hash_ring_router_unit_macros.svh"
module consistent_hash_ring_router_unit
    import chr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);
    typedef enum logic [4:0] {
        S_IDLE, S_LSRCH, S_LRD, S_LWAIT, S_LDONE,
        S_ACHK, S_ASRCH, S_ASWAIT, S_ADNEXT, S_AINS, S_ASHRD, S_ASHWR, S_APUT,
        S_RSCAN, S_RSWAIT, S_RNSH, S_RNSWAIT, S_RCRD, S_RCWAIT, S_DONE
    } t_state;

    t_state r_state;
    t_in_beat r_in;
    logic [NodeCw-1:0] r_node_total;
    logic [RingCw-1:0] r_ring_total;
    logic [31:0] r_ver;
    logic [31:0] r_last_id;
    logic [RingCw-1:0] r_lo, r_hi, r_i, r_w;
    logic [1:0] r_h;
    logic r_out_valid;
    t_out_beat r_out;

    // memory ports
    logic ring_we, node_we;
    logic [RingAw-1:0] ring_waddr, ring_raddr;
    logic [63:0] key_wdata, key_rdata;
    logic [31:0] own_wdata, own_rdata;
    logic [NodeAw-1:0] node_waddr, node_raddr;
    logic [31:0] node_wdata, node_rdata;

    chr_ram #(.Width(64), .Depth(RingDepth)) u_keys (
        .i_clk(i_clk), .i_we(ring_we), .i_waddr(ring_waddr), .i_wdata(key_wdata),
        .i_raddr(ring_raddr), .o_rdata(key_rdata));
    chr_ram #(.Width(32), .Depth(RingDepth)) u_owners (
        .i_clk(i_clk), .i_we(ring_we), .i_waddr(ring_waddr), .i_wdata(own_wdata),
        .i_raddr(ring_raddr), .o_rdata(own_rdata));
    chr_ram #(.Width(32), .Depth(MaxNodes)) u_nodes (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(node_raddr), .o_rdata(node_rdata));

    // current vnode hash under test or insert
    logic [63:0] cur_h;
    always_comb begin
        unique case (r_h)
            2'd0:    cur_h = r_in.vnode_hash_a;
            2'd1:    cur_h = r_in.vnode_hash_b;
            default: cur_h = r_in.vnode_hash_c;
        endcase
    end

    logic [RingCw-1:0] mid;
    assign mid = r_lo + ((r_hi - r_lo) >> 1);

    // memory control from state
    always_comb begin
        ring_we    = 1'b0;
        node_we    = 1'b0;
        ring_waddr = r_i[RingAw-1:0];
        ring_raddr = mid[RingAw-1:0];
        key_wdata  = key_rdata;
        own_wdata  = own_rdata;
        node_waddr = r_i[NodeAw-1:0];
        node_raddr = r_i[NodeAw-1:0];
        node_wdata = node_rdata;
        unique case (r_state)
            S_ASHRD: ring_raddr = RingAw'(r_i - 1'b1);
            S_ASHWR: begin
                ring_we   = 1'b1;
                key_wdata = key_rdata;
                own_wdata = own_rdata;
            end
            S_APUT: begin
                ring_we   = 1'b1;
                key_wdata = cur_h;
                own_wdata = r_in.node_id;
                if (r_h == 2'(Placed - 1)) begin
                    node_we    = 1'b1;
                    node_waddr = r_node_total[NodeAw-1:0];
                    node_wdata = r_in.node_id;
                end
            end
            S_RSCAN: node_raddr = r_i[NodeAw-1:0];
            S_RNSH:  node_raddr = NodeAw'(r_i + 1'b1);
            S_RNSWAIT: node_we = 1'b1;
            S_RCRD:  ring_raddr = r_i[RingAw-1:0];
            S_RCWAIT: begin
                ring_we    = (own_rdata != r_in.node_id);
                ring_waddr = r_w[RingAw-1:0];
                key_wdata  = key_rdata;
                own_wdata  = own_rdata;
            end
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_total <= '0;
            r_ring_total <= '0;
            r_ver        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !o_in_stall) begin
                        r_in <= i_in_data;
                        r_lo <= '0;
                        r_hi <= r_ring_total;
                        r_h  <= '0;
                        r_i  <= '0;
                        r_w  <= '0;
                        priority if (i_in_data.operation == OpLookup) begin
                            if (r_ring_total == '0) begin
                                r_out.status     <= StEmpty;
                                r_out.owner_node <= '1;
                                r_state <= S_DONE;
                            end else begin
                                r_out.status     <= StOk;
                                r_out.owner_node <= '0;
                                r_state <= S_LSRCH;
                            end
                        end else if (i_in_data.operation == OpAdd) begin
                            r_out.status     <= StOk;
                            r_out.owner_node <= '0;
                            r_state <= S_ACHK;
                        end else if (i_in_data.operation == OpRemove) begin
                            r_out.status     <= StOk;
                            r_out.owner_node <= '0;
                            r_state <= S_RSCAN;
                        end else begin
                            r_out.status     <= StOk;
                            r_out.owner_node <= '0;
                            r_state <= S_DONE;
                        end
                    end
                end
                // lookup: binary search, each probe read through S_LSRCH and S_LRD
                S_LSRCH: r_state <= (r_lo < r_hi) ? S_LRD : S_LWAIT;
                S_LRD: begin
                    if (key_rdata < r_in.key_hash) r_lo <= mid + 1'b1;
                    else                           r_hi <= mid;
                    r_state <= S_LSRCH;
                end
                S_LWAIT: begin
                    if (r_lo >= r_ring_total) begin
                        r_lo <= '0;
                        r_hi <= '0;
                    end else begin
                        r_hi <= r_lo;
                    end
                    r_state <= S_LDONE;
                end
                S_LDONE: begin
                    // mid equals r_lo here; the read issued here is used in S_DONE
                    r_state <= S_DONE;
                end
                // add: checks
                S_ACHK: begin
                    priority if (r_node_total != '0 && r_last_id >= r_in.node_id) begin
                        r_out.status <= StIdLow;
                        r_state <= S_DONE;
                    end else if (r_node_total >= NodeCw'(MaxNodes)) begin
                        r_out.status <= StFull;
                        r_state <= S_DONE;
                    end else if ((Placed > 1 && r_in.vnode_hash_a == r_in.vnode_hash_b) ||
                                 (Placed > 2 && (r_in.vnode_hash_c == r_in.vnode_hash_a ||
                                                 r_in.vnode_hash_c == r_in.vnode_hash_b))) begin
                        r_out.status <= StDup;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_ASRCH;
                    end
                end
                S_ASRCH: r_state <= (r_lo < r_hi) ? S_ASWAIT : S_ADNEXT;
                S_ASWAIT: begin
                    if (key_rdata < cur_h) r_lo <= mid + 1'b1;
                    else                   r_hi <= mid;
                    r_state <= S_ASRCH;
                end
                S_ADNEXT: begin
                    // probe at r_lo read; compare once data valid
                    r_hi    <= r_lo;
                    r_state <= S_AINS;
                end
                S_AINS: begin
                    if (r_lo < r_ring_total && key_rdata == cur_h && !r_w[0]) begin
                        r_out.status <= StDup;
                        r_state <= S_DONE;
                    end else if (!r_w[0]) begin
                        // duplicate pass only; next hash
                        if (r_h == 2'(Placed - 1)) begin
                            r_h  <= '0;
                            r_w  <= RingCw'(1);
                            r_state <= S_ASRCH;
                        end else begin
                            r_h <= r_h + 1'b1;
                            r_state <= S_ASRCH;
                        end
                        r_lo <= '0;
                        r_hi <= r_ring_total;
                    end else begin
                        // insert pass: shift tail from ring_total down to r_lo
                        r_i <= r_ring_total;
                        r_state <= (r_ring_total > r_lo) ? S_ASHRD : S_APUT;
                    end
                end
                S_ASHRD: r_state <= S_ASHWR;
                S_ASHWR: begin
                    r_i <= r_i - 1'b1;
                    r_state <= (r_i - 1'b1 > r_lo) ? S_ASHRD : S_APUT;
                end
                S_APUT: begin
                    r_ring_total <= r_ring_total + 1'b1;
                    if (r_h == 2'(Placed - 1)) begin
                        r_node_total <= r_node_total + 1'b1;
                        r_last_id    <= r_in.node_id;
                        r_ver        <= r_ver + 1'b1;
                        r_state      <= S_DONE;
                    end else begin
                        r_h  <= r_h + 1'b1;
                        r_lo <= '0;
                        r_hi <= r_ring_total + 1'b1;
                        r_state <= S_ASRCH;
                    end
                end
                // remove: scan node list
                S_RSCAN: begin
                    if (r_i >= RingCw'(r_node_total)) begin
                        r_out.status <= StNotFound;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_RSWAIT;
                    end
                end
                S_RSWAIT: begin
                    if (node_rdata == r_in.node_id) begin
                        r_state <= S_RNSH;
                    end else begin
                        // last id passed so far; new largest if the tail goes
                        r_last_id <= node_rdata;
                        r_i <= r_i + 1'b1;
                        r_state <= S_RSCAN;
                    end
                end
                S_RNSH: begin
                    if (r_i + 1'b1 >= RingCw'(r_node_total)) begin
                        r_node_total <= r_node_total - 1'b1;
                        r_i <= '0;
                        r_state <= S_RCRD;
                    end else begin
                        r_state <= S_RNSWAIT;
                    end
                end
                S_RNSWAIT: begin
                    if (r_i + 2'd2 >= RingCw'(r_node_total)) r_last_id <= node_rdata;
                    r_i <= r_i + 1'b1;
                    r_state <= S_RNSH;
                end
                S_RCRD: begin
                    if (r_i >= r_ring_total) begin
                        r_ring_total <= r_w;
                        r_ver <= r_ver + 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_RCWAIT;
                    end
                end
                S_RCWAIT: begin
                    if (own_rdata != r_in.node_id) r_w <= r_w + 1'b1;
                    r_i <= r_i + 1'b1;
                    r_state <= S_RCRD;
                end
                S_DONE: begin
                    if (r_in.operation == OpLookup && r_ring_total != '0) begin
                        r_out.owner_node <= own_rdata;
                    end
                    r_out.ring_version <= r_ver;
                    r_out.nodes_held   <= 5'(r_node_total);
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `CHR_ASSERT(a_ring_bound, i_clk, i_rst_n, r_ring_total <= RingCw'(RingDepth), "ring overflow")
    `CHR_ASSERT(a_node_bound, i_clk, i_rst_n, r_node_total <= NodeCw'(MaxNodes), "node overflow")
    `CHR_ASSERT_NEXT(a_one_beat, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state != S_IDLE, "beat lost")
endmodule

/* tb/tb_consistent_hash_ring_router_unit.sv */
// Self-checking bench for the consistent hash ring router unit.
// Depends on chr_pkg and the router top level; predicts each output beat.
module tb_consistent_hash_ring_router_unit;
    import chr_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out_data;

    consistent_hash_ring_router_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    localparam int NumRandom = 1300;

    // Predicted ring contents
    logic [31:0] pr_nodes [MaxNodes];
    int          pr_node_cnt;
    logic [63:0] pr_keys [RingDepth];
    logic [31:0] pr_owners [RingDepth];
    int          pr_ring_cnt;
    logic [31:0] pr_version;

    t_out_beat route_expect_q[$];
    int        mismatch_cnt;
    int        send_idle_pct;
    int        recv_idle_pct;

    // Directed rows; dir_chk marks rows with typed-in expectations
    t_in_beat  dir_tbl[$];
    t_out_beat dir_exp[$];
    bit        dir_chk[$];

    always begin
        i_clk = 1'b0; #1;
        i_clk = 1'b1; #1;
    end

    // First ring index with key not below k
    function automatic int ring_lower(logic [63:0] k);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = pr_ring_cnt;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (pr_keys[mid] < k) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic bit ring_holds(logic [63:0] k);
        int p;
        p = ring_lower(k);
        return (p < pr_ring_cnt) && (pr_keys[p] == k);
    endfunction

    // Predict one beat and update the ring copy
    function automatic t_out_beat route_predict(t_in_beat b);
        t_out_beat   r;
        logic [63:0] h[3];
        int          p;
        int          w;
        int          pos;
        bit          dup;
        r = '0;
        r.status = StOk;
        h[0] = b.vnode_hash_a;
        h[1] = b.vnode_hash_b;
        h[2] = b.vnode_hash_c;
        if (b.operation == OpLookup) begin
            if (pr_ring_cnt == 0) begin
                r.status = StEmpty;
                r.owner_node = '1;
            end else begin
                p = ring_lower(b.key_hash);
                if (p >= pr_ring_cnt) p = 0;
                r.owner_node = pr_owners[p];
            end
        end else if (b.operation == OpAdd) begin
            dup = 1'b0;
            for (int i = 0; i < Placed; i++) begin
                if (ring_holds(h[i])) dup = 1'b1;
                for (int j = 0; j < i; j++)
                    if (h[j] == h[i]) dup = 1'b1;
            end
            if (pr_node_cnt > 0 && pr_nodes[pr_node_cnt-1] >= b.node_id) begin
                r.status = StIdLow;
            end else if (pr_node_cnt >= MaxNodes) begin
                r.status = StFull;
            end else if (dup) begin
                r.status = StDup;
            end else begin
                for (int i = 0; i < Placed; i++) begin
                    p = ring_lower(h[i]);
                    for (int k = pr_ring_cnt; k > p; k--) begin
                        pr_keys[k] = pr_keys[k-1];
                        pr_owners[k] = pr_owners[k-1];
                    end
                    pr_keys[p] = h[i];
                    pr_owners[p] = b.node_id;
                    pr_ring_cnt++;
                end
                pr_nodes[pr_node_cnt] = b.node_id;
                pr_node_cnt++;
                pr_version++;
            end
        end else if (b.operation == OpRemove) begin
            pos = -1;
            for (int i = 0; i < pr_node_cnt; i++)
                if (pos < 0 && pr_nodes[i] == b.node_id) pos = i;
            if (pos < 0) begin
                r.status = StNotFound;
            end else begin
                for (int i = pos; i + 1 < pr_node_cnt; i++) pr_nodes[i] = pr_nodes[i+1];
                pr_node_cnt--;
                w = 0;
                for (int i = 0; i < pr_ring_cnt; i++) begin
                    if (pr_owners[i] != b.node_id) begin
                        pr_keys[w] = pr_keys[i];
                        pr_owners[w] = pr_owners[i];
                        w++;
                    end
                end
                pr_ring_cnt = w;
                pr_version++;
            end
        end
        r.ring_version = pr_version;
        r.nodes_held = pr_node_cnt[4:0];
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_in_beat mk_beat(logic [1:0] op, logic [63:0] key,
                                         logic [31:0] id, logic [63:0] ha,
                                         logic [63:0] hb, logic [63:0] hc);
        t_in_beat b;
        b.operation = op;
        b.key_hash = key;
        b.node_id = id;
        b.vnode_hash_a = ha;
        b.vnode_hash_b = hb;
        b.vnode_hash_c = hc;
        return b;
    endfunction

    function automatic t_out_beat mk_res(logic [2:0] st, logic [31:0] own,
                                         logic [31:0] ver, logic [4:0] held);
        t_out_beat r;
        r.status = st;
        r.owner_node = own;
        r.ring_version = ver;
        r.nodes_held = held;
        return r;
    endfunction

    // Random beat: lookups, adds mostly with fresh ids, removes mostly of held nodes, rarely an undefined operation
    function automatic t_in_beat rand_beat();
        t_in_beat    b;
        int          sel;
        logic [31:0] top_id;
        b = mk_beat(OpLookup, rand64(), $urandom(), rand64(), rand64(), rand64());
        sel = $urandom_range(0, 99);
        top_id = (pr_node_cnt > 0) ? pr_nodes[pr_node_cnt-1] : 32'd0;
        if (sel < 45) begin
            b.operation = OpLookup;
            if (pr_ring_cnt > 0 && $urandom_range(0, 3) == 0)
                b.key_hash = pr_keys[$urandom_range(0, pr_ring_cnt-1)]
                             + 64'($urandom_range(0, 2)) - 64'd1;
        end else if (sel < 75) begin
            b.operation = OpAdd;
            if ($urandom_range(0, 9) != 0 && top_id < 32'hFFFF0000)
                b.node_id = top_id + 32'($urandom_range(1, 1000));
            if (pr_ring_cnt > 0 && $urandom_range(0, 9) == 0)
                b.vnode_hash_b = pr_keys[$urandom_range(0, pr_ring_cnt-1)];
            if ($urandom_range(0, 14) == 0) b.vnode_hash_c = b.vnode_hash_a;
        end else if (sel < 97) begin
            b.operation = OpRemove;
            if (pr_node_cnt > 0 && $urandom_range(0, 4) != 0)
                b.node_id = pr_nodes[$urandom_range(0, pr_node_cnt-1)];
        end else begin
            b.operation = 2'd3;
        end
        return b;
    endfunction

    // Send one beat; predicted result goes on the queue at acceptance.
    // Valid is left high after acceptance and set again by the next call.
    task automatic send_beat(t_in_beat b, bit chk, t_out_beat typed);
        t_out_beat pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = route_predict(b);
        if (chk && pred !== typed && mismatch_cnt < 10)
            $display("table row disagrees with predictor: %h vs %h", typed, pred);
        route_expect_q.push_back(chk ? typed : pred);
    endtask

    // Receiver: random stall, compare each beat
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (route_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected beat %h", o_out_data);
            end else begin
                want = route_expect_q.pop_front();
                if (o_out_data.status !== want.status
                    || o_out_data.owner_node !== want.owner_node
                    || o_out_data.ring_version !== want.ring_version
                    || o_out_data.nodes_held !== want.nodes_held) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp st=%0d own=%h ver=%0d held=%0d, got st=%0d own=%h ver=%0d held=%0d",
                                 want.status, want.owner_node, want.ring_version,
                                 want.nodes_held, o_out_data.status,
                                 o_out_data.owner_node, o_out_data.ring_version,
                                 o_out_data.nodes_held);
                end
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Run limit
    initial begin
        #10000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        mismatch_cnt = 0;
        pr_node_cnt = 0;
        pr_ring_cnt = 0;
        pr_version = '0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        send_idle_pct = 8;
        recv_idle_pct = 63;

        // Directed table
        dir_tbl.push_back(mk_beat(OpLookup, '1, '0, '0, '0, '0));
        dir_exp.push_back(mk_res(StEmpty, '1, 32'd0, 5'd0)); dir_chk.push_back(1);
        dir_tbl.push_back(mk_beat(OpRemove, '0, 32'd7, '0, '0, '0));
        dir_exp.push_back(mk_res(StNotFound, '0, 32'd0, 5'd0)); dir_chk.push_back(1);
        dir_tbl.push_back(mk_beat(2'd3, '1, '1, '1, '1, '1));
        dir_exp.push_back(mk_res(StOk, '0, 32'd0, 5'd0)); dir_chk.push_back(1);
        dir_tbl.push_back(mk_beat(OpAdd, '0, 32'd0, 64'd5, 64'd5, 64'd9));
        dir_exp.push_back(mk_res(StDup, '0, 32'd0, 5'd0)); dir_chk.push_back(1);
        dir_tbl.push_back(mk_beat(OpAdd, '0, 32'd0, '0, '1, 64'h8000_0000_0000_0000));
        dir_exp.push_back(mk_res(StOk, '0, 32'd1, 5'd1)); dir_chk.push_back(1);
        dir_tbl.push_back(mk_beat(OpAdd, '0, 32'd0, 64'd1, 64'd2, 64'd3));
        dir_exp.push_back(mk_res(StIdLow, '0, 32'd1, 5'd1)); dir_chk.push_back(1);
        dir_tbl.push_back(mk_beat(OpAdd, '0, 32'd4, 64'd1, '1, 64'd3));
        dir_exp.push_back(mk_res(StDup, '0, 32'd1, 5'd1)); dir_chk.push_back(1);
        dir_tbl.push_back(mk_beat(OpAdd, '0, '1, 64'd10, 64'd20, 64'd30));
        dir_exp.push_back(mk_res(StOk, '0, 32'd2, 5'd2)); dir_chk.push_back(1);
        dir_tbl.push_back(mk_beat(OpLookup, '0, '0, '0, '0, '0));
        dir_exp.push_back('0); dir_chk.push_back(0);
        dir_tbl.push_back(mk_beat(OpLookup, 64'd15, '0, '0, '0, '0));
        dir_exp.push_back('0); dir_chk.push_back(0);
        dir_tbl.push_back(mk_beat(OpLookup, '1, '0, '0, '0, '0));
        dir_exp.push_back('0); dir_chk.push_back(0);
        dir_tbl.push_back(mk_beat(OpLookup, 64'h8000_0000_0000_0001, '0, '0, '0, '0));
        dir_exp.push_back('0); dir_chk.push_back(0);
        dir_tbl.push_back(mk_beat(OpAdd, '0, 32'd9, 64'd40, 64'd41, 64'd42));
        dir_exp.push_back(mk_res(StIdLow, '0, 32'd2, 5'd2)); dir_chk.push_back(1);
        dir_tbl.push_back(mk_beat(OpRemove, '0, 32'd0, '0, '0, '0));
        dir_exp.push_back(mk_res(StOk, '0, 32'd3, 5'd1)); dir_chk.push_back(1);
        dir_tbl.push_back(mk_beat(OpLookup, 64'd11, '0, '0, '0, '0));
        dir_exp.push_back(mk_res(StOk, '1, 32'd3, 5'd1)); dir_chk.push_back(1);
        dir_tbl.push_back(mk_beat(OpRemove, '0, '1, '0, '0, '0));
        dir_exp.push_back(mk_res(StOk, '0, 32'd4, 5'd0)); dir_chk.push_back(1);
        dir_tbl.push_back(mk_beat(OpLookup, 64'd11, '0, '0, '0, '0));
        dir_exp.push_back(mk_res(StEmpty, '1, 32'd4, 5'd0)); dir_chk.push_back(1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i]) send_beat(dir_tbl[i], dir_chk[i], dir_exp[i]);

        // Fill the node table to full, then one more
        for (int n = 0; n <= MaxNodes; n++)
            send_beat(mk_beat(OpAdd, '0, 32'd100 + 32'(n), rand64(), rand64(), rand64()),
                      0, '0);

        // Random phases with different idling
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 63 : 0;
            recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 8 : 0;
            for (int k = 0; k < NumRandom / 3; k++) send_beat(rand_beat(), 0, '0);
        end
        i_in_valid <= 1'b0;

        while (route_expect_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (mismatch_cnt == 0 && route_expect_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+src
src/chr_pkg.sv
src/chr_ram.sv
src/consistent_hash_ring_router_unit.sv
tb/tb_consistent_hash_ring_router_unit.sv
